// ----- hdl/jsu_pkg.sv -----
// Shared types and codes of the JSON string unescape / UTF-8 check core.
// No dependencies; imported by the front end, the job queue, the back end and the top.
package jsu_pkg;

    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_CLOSED = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [2:0] ERR_NONE  = 3'd0;
    localparam logic [2:0] ERR_CTRL  = 3'd1;
    localparam logic [2:0] ERR_ESC   = 3'd2;
    localparam logic [2:0] ERR_HEX   = 3'd3;
    localparam logic [2:0] ERR_SURR  = 3'd4;
    localparam logic [2:0] ERR_UTF8  = 3'd5;
    localparam logic [2:0] ERR_TRUNC = 3'd6;

    localparam int CP_W = 21;

    // One decoded event: a code point to encode, or a close / error marker.
    typedef struct packed {
        logic [1:0]      kind;
        logic [2:0]      cause;
        logic [CP_W-1:0] cp;
    } job_t;

endpackage

// ----- hdl/jsu_in_if.sv -----
// Input channel of the unescape core: one raw string byte or end-of-text per word.
// No dependencies.
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_text;

    modport source (output valid, in_byte, end_of_text, input ready);
    modport sink   (input valid, in_byte, end_of_text, output ready);
endinterface

// ----- hdl/jsu_out_if.sv -----
// Result channel of the unescape core: one decoded byte, close or error per word.
// No dependencies.
interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [2:0] error_cause;
    logic       last;

    modport source (output valid, out_byte, kind, error_cause, last, input ready);
    modport sink   (input valid, out_byte, kind, error_cause, last, output ready);
endinterface

// ----- hdl/jsu_front.sv -----
// Front end: takes one input word per cycle if not full, tracks escape / hex / UTF-8
// state, pushes one job per word that yields results. Depends on jsu_pkg, jsu_in_if.
module jsu_front
    import jsu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    jsu_in_if.sink   text,
    input  logic     full,
    output logic     push,
    output job_t     push_job
);

    localparam logic [3:0] PH_IDLE = 4'd0;
    localparam logic [3:0] PH_ESC  = 4'd1;
    localparam logic [3:0] PH_HEX1 = 4'd2;
    localparam logic [3:0] PH_BSL  = 4'd3;
    localparam logic [3:0] PH_U    = 4'd4;
    localparam logic [3:0] PH_HEX2 = 4'd5;
    localparam logic [3:0] PH_UTF8 = 4'd6;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6e;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    logic [3:0]      phase_reg, phase_next;
    logic [CP_W-1:0] cp_reg, cp_next;
    logic [1:0]      hex_count_reg, hex_count_next;
    logic [9:0]      high_half_reg, high_half_next;
    logic [1:0]      utf8_left_reg, utf8_left_next;
    logic [1:0]      utf8_length_reg, utf8_length_next;

    logic            accept;
    logic [7:0]      c;
    logic            hex_ok;
    logic [3:0]      hex_d;
    logic [15:0]     hex_acc;
    logic [CP_W-1:0] utf8_acc;
    logic [CP_W-1:0] utf8_min;

    assign text.ready = !full;
    assign accept     = text.valid && !full;
    assign c          = text.in_byte;

    always_comb
    begin
        hex_ok = 1'b1;
        hex_d  = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            hex_d = c[3:0];
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            hex_d = c[3:0] + 4'd9;
        end
        else
        begin
            hex_ok = 1'b0;
        end
    end

    assign hex_acc  = {cp_reg[11:0], hex_d};
    assign utf8_acc = {cp_reg[CP_W-7:0], c[5:0]};

    always_comb
    begin
        case (utf8_length_reg)
            2'd1:    utf8_min = 21'h00080;
            2'd2:    utf8_min = 21'h00800;
            default: utf8_min = 21'h10000;
        endcase
    end

    always_comb
    begin
        phase_next       = phase_reg;
        cp_next          = cp_reg;
        hex_count_next   = hex_count_reg;
        high_half_next   = high_half_reg;
        utf8_left_next   = utf8_left_reg;
        utf8_length_next = utf8_length_reg;
        push             = 1'b0;
        push_job         = '0;

        if (text.end_of_text)
        begin
            push           = 1'b1;
            push_job.kind  = KIND_ERROR;
            push_job.cause = ERR_TRUNC;
        end
        else
        begin
            case (phase_reg)
                PH_ESC:
                begin
                    phase_next = PH_IDLE;
                    push       = 1'b1;
                    case (c)
                        CH_QUOTE, CH_BSL, CH_SLASH: push_job.cp = {13'd0, c};
                        CH_B:    push_job.cp = 21'h08;
                        CH_F:    push_job.cp = 21'h0c;
                        CH_N:    push_job.cp = 21'h0a;
                        CH_R:    push_job.cp = 21'h0d;
                        CH_T:    push_job.cp = 21'h09;
                        CH_U:
                        begin
                            push           = 1'b0;
                            phase_next     = PH_HEX1;
                            cp_next        = '0;
                            hex_count_next = 2'd0;
                        end
                        default:
                        begin
                            push_job.kind  = KIND_ERROR;
                            push_job.cause = ERR_ESC;
                        end
                    endcase
                end
                PH_HEX1, PH_HEX2:
                begin
                    if (!hex_ok)
                    begin
                        push           = 1'b1;
                        push_job.kind  = KIND_ERROR;
                        push_job.cause = ERR_HEX;
                    end
                    else if (hex_count_reg != 2'd3)
                    begin
                        cp_next        = {5'd0, hex_acc};
                        hex_count_next = hex_count_reg + 2'd1;
                    end
                    else if (phase_reg == PH_HEX1)
                    begin
                        hex_count_next = 2'd0;
                        if (hex_acc >= 16'hd800 && hex_acc <= 16'hdbff)
                        begin
                            high_half_next = hex_acc[9:0];
                            cp_next        = '0;
                            phase_next     = PH_BSL;
                        end
                        else if (hex_acc >= 16'hdc00 && hex_acc <= 16'hdfff)
                        begin
                            push           = 1'b1;
                            push_job.kind  = KIND_ERROR;
                            push_job.cause = ERR_SURR;
                        end
                        else
                        begin
                            push        = 1'b1;
                            push_job.cp = {5'd0, hex_acc};
                        end
                    end
                    else
                    begin
                        push = 1'b1;
                        if (hex_acc < 16'hdc00 || hex_acc > 16'hdfff)
                        begin
                            push_job.kind  = KIND_ERROR;
                            push_job.cause = ERR_SURR;
                        end
                        else
                        begin
                            push_job.cp = 21'h10000 + {1'b0, high_half_reg, hex_acc[9:0]};
                        end
                    end
                end
                PH_BSL:
                begin
                    if (c != CH_BSL)
                    begin
                        push           = 1'b1;
                        push_job.kind  = KIND_ERROR;
                        push_job.cause = ERR_SURR;
                    end
                    else
                    begin
                        phase_next = PH_U;
                    end
                end
                PH_U:
                begin
                    if (c != CH_U)
                    begin
                        push           = 1'b1;
                        push_job.kind  = KIND_ERROR;
                        push_job.cause = ERR_SURR;
                    end
                    else
                    begin
                        phase_next     = PH_HEX2;
                        cp_next        = '0;
                        hex_count_next = 2'd0;
                    end
                end
                PH_UTF8:
                begin
                    if (c[7:6] != 2'b10)
                    begin
                        push           = 1'b1;
                        push_job.kind  = KIND_ERROR;
                        push_job.cause = ERR_UTF8;
                    end
                    else if (utf8_left_reg > 2'd1)
                    begin
                        cp_next        = utf8_acc;
                        utf8_left_next = utf8_left_reg - 2'd1;
                    end
                    else
                    begin
                        push = 1'b1;
                        if (utf8_acc < utf8_min || utf8_acc > 21'h10ffff ||
                            (utf8_acc >= 21'h0d800 && utf8_acc <= 21'h0dfff))
                        begin
                            push_job.kind  = KIND_ERROR;
                            push_job.cause = ERR_UTF8;
                        end
                        else
                        begin
                            push_job.cp = utf8_acc;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    if (c == CH_QUOTE)
                    begin
                        push          = 1'b1;
                        push_job.kind = KIND_CLOSED;
                    end
                    else if (c < 8'h20)
                    begin
                        push           = 1'b1;
                        push_job.kind  = KIND_ERROR;
                        push_job.cause = ERR_CTRL;
                    end
                    else if (c == CH_BSL)
                    begin
                        phase_next = PH_ESC;
                    end
                    else if (!c[7])
                    begin
                        push        = 1'b1;
                        push_job.cp = {13'd0, c};
                    end
                    else if (c >= 8'hc2 && c <= 8'hdf)
                    begin
                        cp_next          = {16'd0, c[4:0]};
                        utf8_length_next = 2'd1;
                        utf8_left_next   = 2'd1;
                        phase_next       = PH_UTF8;
                    end
                    else if (c >= 8'he0 && c <= 8'hef)
                    begin
                        cp_next          = {17'd0, c[3:0]};
                        utf8_length_next = 2'd2;
                        utf8_left_next   = 2'd2;
                        phase_next       = PH_UTF8;
                    end
                    else if (c >= 8'hf0 && c <= 8'hf4)
                    begin
                        cp_next          = {18'd0, c[2:0]};
                        utf8_length_next = 2'd3;
                        utf8_left_next   = 2'd3;
                        phase_next       = PH_UTF8;
                    end
                    else
                    begin
                        push           = 1'b1;
                        push_job.kind  = KIND_ERROR;
                        push_job.cause = ERR_UTF8;
                    end
                end
            endcase
        end

        // any result other than a simple escape's byte ends the sequence: drop all state
        if (push && !(phase_reg == PH_ESC && push_job.kind == KIND_BYTE && !text.end_of_text))
        begin
            phase_next       = PH_IDLE;
            cp_next          = '0;
            hex_count_next   = 2'd0;
            high_half_next   = 10'd0;
            utf8_left_next   = 2'd0;
            utf8_length_next = 2'd0;
        end

        if (!accept)
        begin
            push = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            cp_reg          <= '0;
            hex_count_reg   <= 2'd0;
            high_half_reg   <= 10'd0;
            utf8_left_reg   <= 2'd0;
            utf8_length_reg <= 2'd0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            cp_reg          <= cp_next;
            hex_count_reg   <= hex_count_next;
            high_half_reg   <= high_half_next;
            utf8_left_reg   <= utf8_left_next;
            utf8_length_reg <= utf8_length_next;
        end
    end

endmodule

// ----- hdl/jsu_queue.sv -----
// Short job queue between front end and back end, held in flip-flops.
// Depends on jsu_pkg.
module jsu_queue
    import jsu_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output job_t head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ----- hdl/jsu_back.sv -----
// Back end: turns the job at the queue head into one to four result words
// and holds them in an output register. Depends on jsu_pkg, jsu_out_if.
module jsu_back
    import jsu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  job_t      head_job,
    output logic      pop,
    jsu_out_if.source result
);

    logic       out_valid_reg;
    logic [7:0] out_byte_reg, out_byte_next;
    logic [1:0] kind_reg;
    logic [2:0] cause_reg;
    logic       last_reg, last_next;
    logic [1:0] idx_reg;
    logic [1:0] top_idx;
    logic       load;
    logic [CP_W-1:0] cp;

    assign cp   = head_job.cp;
    assign load = head_valid && (!out_valid_reg || result.ready);

    always_comb
    begin
        if (head_job.kind != KIND_BYTE || cp < 21'h00080)
        begin
            top_idx = 2'd0;
        end
        else if (cp < 21'h00800)
        begin
            top_idx = 2'd1;
        end
        else if (cp < 21'h10000)
        begin
            top_idx = 2'd2;
        end
        else
        begin
            top_idx = 2'd3;
        end
    end

    always_comb
    begin
        out_byte_next = 8'd0;
        if (head_job.kind == KIND_BYTE)
        begin
            case (top_idx)
                2'd0: out_byte_next = cp[7:0];
                2'd1:
                begin
                    case (idx_reg)
                        2'd0:    out_byte_next = {3'b110, cp[10:6]};
                        default: out_byte_next = {2'b10, cp[5:0]};
                    endcase
                end
                2'd2:
                begin
                    case (idx_reg)
                        2'd0:    out_byte_next = {4'b1110, cp[15:12]};
                        2'd1:    out_byte_next = {2'b10, cp[11:6]};
                        default: out_byte_next = {2'b10, cp[5:0]};
                    endcase
                end
                default:
                begin
                    case (idx_reg)
                        2'd0:    out_byte_next = {5'b11110, cp[20:18]};
                        2'd1:    out_byte_next = {2'b10, cp[17:12]};
                        2'd2:    out_byte_next = {2'b10, cp[11:6]};
                        default: out_byte_next = {2'b10, cp[5:0]};
                    endcase
                end
            endcase
        end
    end

    assign last_next = (idx_reg == top_idx);
    assign pop       = load && last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= last_next ? 2'd0 : idx_reg + 2'd1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= out_byte_next;
            kind_reg     <= head_job.kind;
            cause_reg    <= head_job.cause;
            last_reg     <= last_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.out_byte    = out_byte_reg;
    assign result.kind        = kind_reg;
    assign result.error_cause = cause_reg;
    assign result.last        = last_reg;

endmodule

// ----- hdl/json_string_unescape_utf8_core.sv -----
// Top level of the JSON string unescape / UTF-8 check core.
// Depends on jsu_pkg, jsu_in_if, jsu_out_if, jsu_front, jsu_queue, jsu_back.
//
// Usage:
//   text   : one word per byte of a string body, starting after the opening
//            quote; end_of_text set marks the end of the text instead.
//   result : one word per decoded UTF-8 byte (kind 0), a close (kind 1) or an
//            error (kind 2, error_cause set); last marks the final word of a
//            text word. A close or error returns the decoder to its start.
//   Path: a word that yields results shows its first result after passing a
//            queue slot, then the output register.
//   Throughput: one text word per cycle while the queue is not full; the back
//            end sends one result word per cycle while result.ready is high and
//            one word per UTF-8 byte; QUEUE_DEPTH jobs absorb such bursts.
//   Stall: while result.ready is low the output word holds; the queue fills
//            and text.ready drops once it is full.
//   Reset: rst_n clears the decoder state, empties the queue and drops
//            result.valid; the block takes a word as soon as reset is released.
module json_string_unescape_utf8_core
    import jsu_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    jsu_in_if.sink    text,
    jsu_out_if.source result
);

    logic push;
    job_t push_job;
    logic full;
    logic pop;
    logic head_valid;
    job_t head_job;

    jsu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .text     (text),
        .full     (full),
        .push     (push),
        .push_job (push_job)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    jsu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .result     (result)
    );

endmodule
